// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfd_pkg.sv =====
// ---------------------------------------------------------------------------
// rfd_pkg
// types, constants and crc helpers for the frame deframer
// ---------------------------------------------------------------------------
package rfd_pkg;

  localparam int FRAME_MAX_BYTES = 128;
  localparam int OVERHEAD_BYTES  = 9;
  localparam int LEN_LIMIT       = FRAME_MAX_BYTES - OVERHEAD_BYTES;
  // byte position after the header crc never exceeds length + 3
  localparam int POS_W           = $clog2(FRAME_MAX_BYTES);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  CRC8_POLY  = 8'h8C;
  localparam logic [15:0] CRC16_POLY = 16'h8408;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    ST_SOF,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_SEQ,
    ST_HCRC,
    ST_BODY
  } step_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE      = 2'd0,
    REG_HEADER_CRC_INIT = 2'd1,
    REG_FRAME_CRC_INIT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  header_crc_init;
    logic [15:0] frame_crc_init;
  } cfg_t;

  typedef struct packed {
    step_t       step;
    pos_t        pos;
    logic [7:0]  len_lo;
    pos_t        len;
    logic [7:0]  header_crc;
    logic [15:0] frame_crc;
    logic [15:0] cmd;
    logic [7:0]  seq;
    logic [7:0]  crc_low;
  } parse_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] command_id;
    logic [6:0]  payload_length;
    logic [7:0]  sequence_res;
    logic        last;
  } result_t;

  // reflected crc8, one byte
  function automatic logic [7:0] crc8_add(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC8_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // reflected ccitt crc16, one byte
  function automatic logic [15:0] crc16_add(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== rtl/rfd_step.sv =====
// ---------------------------------------------------------------------------
// rfd_step
// next parse state and result for one received byte
// ---------------------------------------------------------------------------
module rfd_step (
  input  rfd_pkg::parse_t  cur,
  input  rfd_pkg::cfg_t    cfg,
  input  logic [7:0]       in_byte,
  output rfd_pkg::parse_t  nxt,
  output rfd_pkg::result_t res,
  output logic             res_valid
);

  logic [15:0]             len_full;
  logic [rfd_pkg::POS_W:0] pos_ext;
  logic [rfd_pkg::POS_W:0] len_p2;
  logic [7:0]              hcrc_upd;
  logic [15:0]             fcrc_upd;
  logic                    crc_good;

  assign len_full = {in_byte, cur.len_lo};
  assign pos_ext  = {1'b0, cur.pos};
  assign len_p2   = {1'b0, cur.len} + (rfd_pkg::POS_W + 1)'(2);
  assign hcrc_upd = rfd_pkg::crc8_add(cur.header_crc, in_byte);
  assign fcrc_upd = rfd_pkg::crc16_add(cur.frame_crc, in_byte);
  assign crc_good = (cur.frame_crc[7:0] == cur.crc_low) && (cur.frame_crc[15:8] == in_byte);

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res.kind           = rfd_pkg::KIND_PAYLOAD;
    res.payload_byte   = 8'h00;
    res.command_id     = 16'h0000;
    res.payload_length = 7'(16'(cur.len));
    res.sequence_res   = 8'h00;
    res.last           = 1'b0;

    case (cur.step)
      rfd_pkg::ST_SOF: begin
        if (in_byte == cfg.start_byte) begin
          nxt.header_crc = rfd_pkg::crc8_add(cfg.header_crc_init, in_byte);
          nxt.frame_crc  = rfd_pkg::crc16_add(cfg.frame_crc_init, in_byte);
          nxt.step       = rfd_pkg::ST_LEN_LO;
        end
      end
      rfd_pkg::ST_LEN_LO: begin
        nxt.len_lo     = in_byte;
        nxt.header_crc = hcrc_upd;
        nxt.frame_crc  = fcrc_upd;
        nxt.step       = rfd_pkg::ST_LEN_HI;
      end
      rfd_pkg::ST_LEN_HI: begin
        nxt.len        = len_full[rfd_pkg::POS_W-1:0];
        nxt.header_crc = hcrc_upd;
        nxt.frame_crc  = fcrc_upd;
        // oversize length drops the frame
        nxt.step = (len_full < 16'(rfd_pkg::LEN_LIMIT)) ? rfd_pkg::ST_SEQ : rfd_pkg::ST_SOF;
      end
      rfd_pkg::ST_SEQ: begin
        nxt.seq        = in_byte;
        nxt.header_crc = hcrc_upd;
        nxt.frame_crc  = fcrc_upd;
        nxt.step       = rfd_pkg::ST_HCRC;
      end
      rfd_pkg::ST_HCRC: begin
        if (in_byte == cur.header_crc) begin
          nxt.frame_crc = fcrc_upd;
          nxt.pos       = '0;
          nxt.step      = rfd_pkg::ST_BODY;
        end else begin
          nxt.step = rfd_pkg::ST_SOF;
        end
      end
      rfd_pkg::ST_BODY: begin
        if (pos_ext < (rfd_pkg::POS_W + 1)'(2)) begin
          // command id, low byte first
          if (cur.pos == '0) begin
            nxt.cmd = {8'h00, in_byte};
          end else begin
            nxt.cmd = {in_byte, cur.cmd[7:0]};
          end
          nxt.frame_crc = fcrc_upd;
          nxt.pos       = cur.pos + 1'b1;
        end else if (pos_ext < len_p2) begin
          nxt.frame_crc    = fcrc_upd;
          nxt.pos          = cur.pos + 1'b1;
          res_valid        = 1'b1;
          res.payload_byte = in_byte;
        end else if (pos_ext == len_p2) begin
          nxt.crc_low = in_byte;
          nxt.pos     = cur.pos + 1'b1;
        end else begin
          nxt.step         = rfd_pkg::ST_SOF;
          nxt.pos          = '0;
          res_valid        = 1'b1;
          res.kind         = crc_good ? rfd_pkg::KIND_GOOD : rfd_pkg::KIND_BAD;
          res.command_id   = cur.cmd;
          res.sequence_res = cur.seq;
          res.last         = 1'b1;
        end
      end
      default: begin
        nxt.step = rfd_pkg::ST_SOF;
        nxt.pos  = '0;
      end
    endcase
  end

endmodule

// ===== rtl/referee_frame_deframer_core.sv =====
// ---------------------------------------------------------------------------
// referee_frame_deframer_core
// byte-serial frame parser with header crc8 and frame crc16 checking
// ---------------------------------------------------------------------------
// usage
//   input channel: one received byte per transfer (in_valid, in_ready, in_byte)
//   output channel: one result per transfer (out_valid, out_ready, kind ...)
//   frame: start byte, length lo/hi, sequence, header crc8, command id lo/hi,
//   payload, crc16 lo/hi; bad header crc8 or oversize length drops silently
//   payload bytes come out as they arrive, the final crc16 byte gives one
//   verdict item (kind good or bad, last set) with command id and sequence
//   timing: a result is on the output register in the cycle after its byte's
//   transfer, and the crc8/crc16 byte update and step logic between input and
//   result register is combinational; one byte per cycle while not stalled
//   stall: the result register holds while out_ready is low; in_ready drops
//   only while a result waits and is not being taken in the same cycle
//   reset: parser returns to hunting for the start byte, output empties, and
//   the config registers take their defaults (start 0xa5, crc inits all ones)
//   config: write cfg_data to register cfg_index when cfg_write is high;
//   crc init values load at the next start byte
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module referee_frame_deframer_core (
  input  logic                           clk,
  input  logic                           rst,
  // config write port
  input  logic                           cfg_write,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data,
  // byte input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  // result output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     kind,
  output logic [7:0]                     payload_byte,
  output logic [15:0]                    command_id,
  output logic [6:0]                     payload_length,
  output logic [7:0]                     sequence_res,
  output logic                           last
);

  rfd_pkg::cfg_t    cfg;
  rfd_pkg::parse_t  state;
  rfd_pkg::parse_t  state_next;
  rfd_pkg::result_t res_next;
  rfd_pkg::result_t res;
  logic             res_next_valid;
  logic             in_xfer;

  // a new byte may enter whenever the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte      <= 8'hA5;
      cfg.header_crc_init <= 8'hFF;
      cfg.frame_crc_init  <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        rfd_pkg::REG_START_BYTE:      cfg.start_byte      <= cfg_data[7:0];
        rfd_pkg::REG_HEADER_CRC_INIT: cfg.header_crc_init <= cfg_data[7:0];
        rfd_pkg::REG_FRAME_CRC_INIT:  cfg.frame_crc_init  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-byte step logic
  rfd_step u_step (
    .cur       (state),
    .cfg       (cfg),
    .in_byte   (in_byte),
    .nxt       (state_next),
    .res       (res_next),
    .res_valid (res_next_valid)
  );

  // parse state: step and position reset, captured fields and crcs just load
  always_ff @(posedge clk) begin
    if (rst) begin
      state.step <= rfd_pkg::ST_SOF;
      state.pos  <= '0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= res_next_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_next_valid) begin
      res <= res_next;
    end
  end

  assign kind           = res.kind;
  assign payload_byte   = res.payload_byte;
  assign command_id     = res.command_id;
  assign payload_length = res.payload_length;
  assign sequence_res   = res.sequence_res;
  assign last           = res.last;

  // checks
  `ASSERT_NOW(a_pos_idle, clk, rst, state.step != rfd_pkg::ST_BODY,
    state.pos == '0, "byte position not cleared outside frame body")
  `ASSERT_NOW(a_pos_bound, clk, rst, state.step == rfd_pkg::ST_BODY,
    {1'b0, state.pos} <= ({1'b0, state.len} + (rfd_pkg::POS_W + 1)'(3)),
    "byte position ran past frame end")
  `ASSERT_NEXT(a_verdict_ends, clk, rst, in_xfer && res_next_valid && res_next.last,
    state.step == rfd_pkg::ST_SOF && out_valid && last,
    "verdict did not close the frame")
  `ASSERT_NOW(a_last_kind, clk, rst, out_valid,
    last == (kind != rfd_pkg::KIND_PAYLOAD), "last flag disagrees with kind")

endmodule

// ===== bench/referee_frame_deframer_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// referee_frame_deframer_checker
// watches the byte, result and register ports of the frame deframer, keeps
// its own model of the parser and compares every result transfer in order
// ---------------------------------------------------------------------------
module referee_frame_deframer_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [7:0]                     in_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     kind,
  input  logic [7:0]                     payload_byte,
  input  logic [15:0]                    command_id,
  input  logic [6:0]                     payload_length,
  input  logic [7:0]                     sequence_res,
  input  logic                           last,
  output int                             mismatch_count,
  output int                             backlog,
  output int                             payload_count,
  output int                             good_count,
  output int                             bad_count
);

  // register copies
  logic [7:0]  start_reg;
  logic [7:0]  hinit_reg;
  logic [15:0] finit_reg;

  // parser copy
  rfd_pkg::step_t parse_at;
  int unsigned    body_pos;
  logic [15:0]    len_word;
  logic [7:0]     hdr_crc;
  logic [15:0]    frm_crc;
  logic [15:0]    cmd_word;
  logic [7:0]     seq_byte;
  logic [7:0]     crc_lo_byte;

  rfd_pkg::result_t due_results[$];

  // serial lsb-first crc8, reflected 0x31
  function automatic logic [7:0] crc8_fold(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] acc;
    logic       fb;
    acc = c;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = {1'b0, acc[7:1]} ^ (fb ? 8'h8C : 8'h00);
    end
    return acc;
  endfunction

  // serial lsb-first crc16, reflected ccitt
  function automatic logic [15:0] crc16_fold(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] acc;
    logic        fb;
    acc = c;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = {1'b0, acc[15:1]} ^ (fb ? 16'h8408 : 16'h0000);
    end
    return acc;
  endfunction

  function automatic rfd_pkg::result_t frame_result(input rfd_pkg::kind_t k,
                                                    input logic [7:0] pb);
    rfd_pkg::result_t r;
    r.kind           = k;
    r.payload_byte   = pb;
    r.command_id     = (k != rfd_pkg::KIND_PAYLOAD) ? cmd_word : 16'h0000;
    r.payload_length = len_word[6:0];
    r.sequence_res   = (k != rfd_pkg::KIND_PAYLOAD) ? seq_byte : 8'h00;
    r.last           = (k != rfd_pkg::KIND_PAYLOAD);
    return r;
  endfunction

  // advance the parser by one accepted byte, queueing any result it causes
  task automatic deframe_byte(input logic [7:0] b);
    logic crc_ok;
    case (parse_at)
      rfd_pkg::ST_SOF: begin
        if (b == start_reg) begin
          hdr_crc  = crc8_fold(hinit_reg, b);
          frm_crc  = crc16_fold(finit_reg, b);
          parse_at = rfd_pkg::ST_LEN_LO;
        end
      end
      rfd_pkg::ST_LEN_LO: begin
        len_word = {8'h00, b};
        hdr_crc  = crc8_fold(hdr_crc, b);
        frm_crc  = crc16_fold(frm_crc, b);
        parse_at = rfd_pkg::ST_LEN_HI;
      end
      rfd_pkg::ST_LEN_HI: begin
        len_word[15:8] = b;
        hdr_crc  = crc8_fold(hdr_crc, b);
        frm_crc  = crc16_fold(frm_crc, b);
        parse_at = (len_word < rfd_pkg::LEN_LIMIT) ? rfd_pkg::ST_SEQ : rfd_pkg::ST_SOF;
      end
      rfd_pkg::ST_SEQ: begin
        seq_byte = b;
        hdr_crc  = crc8_fold(hdr_crc, b);
        frm_crc  = crc16_fold(frm_crc, b);
        parse_at = rfd_pkg::ST_HCRC;
      end
      rfd_pkg::ST_HCRC: begin
        if (b == hdr_crc) begin
          frm_crc  = crc16_fold(frm_crc, b);
          body_pos = 0;
          parse_at = rfd_pkg::ST_BODY;
        end else begin
          parse_at = rfd_pkg::ST_SOF;
        end
      end
      rfd_pkg::ST_BODY: begin
        if (body_pos < 2) begin
          if (body_pos == 0) cmd_word = {8'h00, b};
          else cmd_word[15:8] = b;
          frm_crc  = crc16_fold(frm_crc, b);
          body_pos = body_pos + 1;
        end else if (body_pos < len_word + 2) begin
          frm_crc  = crc16_fold(frm_crc, b);
          body_pos = body_pos + 1;
          due_results.push_back(frame_result(rfd_pkg::KIND_PAYLOAD, b));
        end else if (body_pos == len_word + 2) begin
          crc_lo_byte = b;
          body_pos    = body_pos + 1;
        end else begin
          crc_ok   = (frm_crc[7:0] == crc_lo_byte) && (frm_crc[15:8] == b);
          parse_at = rfd_pkg::ST_SOF;
          body_pos = 0;
          due_results.push_back(frame_result(crc_ok ? rfd_pkg::KIND_GOOD
                                                    : rfd_pkg::KIND_BAD, 8'h00));
        end
      end
      default: begin
        parse_at = rfd_pkg::ST_SOF;
        body_pos = 0;
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    rfd_pkg::result_t exp_r;
    logic             wrong;
    if (rst) begin
      start_reg      = 8'hA5;
      hinit_reg      = 8'hFF;
      finit_reg      = 16'hFFFF;
      parse_at       = rfd_pkg::ST_SOF;
      body_pos       = 0;
      len_word       = '0;
      hdr_crc        = 8'hFF;
      frm_crc        = 16'hFFFF;
      cmd_word       = '0;
      seq_byte       = '0;
      crc_lo_byte    = '0;
      due_results    = {};
      mismatch_count = 0;
      payload_count  = 0;
      good_count     = 0;
      bad_count      = 0;
    end else begin
      // result side first: a result never belongs to a byte of the same edge
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result kind %0d byte %02h cmd %04h", $time,
                     kind, payload_byte, command_id);
          mismatch_count++;
        end else begin
          exp_r = due_results.pop_front();
          wrong = (kind !== exp_r.kind) || (payload_byte !== exp_r.payload_byte) ||
                  (command_id !== exp_r.command_id) ||
                  (payload_length !== exp_r.payload_length) ||
                  (sequence_res !== exp_r.sequence_res) || (last !== exp_r.last);
          if (wrong) begin
            if (mismatch_count < 10) begin
              $display("%0t: mismatch, expected kind %0d byte %02h cmd %04h len %0d seq %02h last %0b",
                       $time, exp_r.kind, exp_r.payload_byte, exp_r.command_id,
                       exp_r.payload_length, exp_r.sequence_res, exp_r.last);
              $display("%0t:           actual   kind %0d byte %02h cmd %04h len %0d seq %02h last %0b",
                       $time, kind, payload_byte, command_id, payload_length,
                       sequence_res, last);
            end
            mismatch_count++;
          end
          case (exp_r.kind)
            rfd_pkg::KIND_PAYLOAD: payload_count++;
            rfd_pkg::KIND_GOOD:    good_count++;
            default:               bad_count++;
          endcase
        end
      end
      // a byte taken on this edge still sees the old register values
      if (in_valid && in_ready) deframe_byte(in_byte);
      if (cfg_write) begin
        case (cfg_index)
          rfd_pkg::REG_START_BYTE:      start_reg = cfg_data[7:0];
          rfd_pkg::REG_HEADER_CRC_INIT: hinit_reg = cfg_data[7:0];
          rfd_pkg::REG_FRAME_CRC_INIT:  finit_reg = cfg_data;
          default: ;
        endcase
      end
    end
    backlog = due_results.size();
  end

endmodule

// ===== bench/tb_referee_frame_deframer_core.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_referee_frame_deframer_core
// drives framed byte streams into the deframer: a short directed set of
// frames (dropped headers, oversize lengths, bad and good crc16, a register
// change mid-frame), then random frames under six register settings and
// three pacing modes, with long output hold-offs; the checker beside the
// block predicts and compares every result transfer
// ---------------------------------------------------------------------------
module tb_referee_frame_deframer_core;

  localparam int HOLD_CYCLES  = 150;   // receiver hold-off, long enough to back up the input
  localparam int STALL_LIMIT  = 3000;  // cycles with no transfer before giving up
  localparam int RANDOM_ITEMS = 1800;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  logic [7:0]                     in_byte   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     kind;
  logic [7:0]                     payload_byte;
  logic [15:0]                    command_id;
  logic [6:0]                     payload_length;
  logic [7:0]                     sequence_res;
  logic                           last;

  int mismatch_count;
  int backlog;
  int payload_count;
  int good_count;
  int bad_count;

  // pacing knobs, written only by the stimulus process
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_req_count = 0;
  // receiver's own bookkeeping
  int hold_seen      = 0;
  int rx_hold_left   = 0;

  int stall_cycles   = 0;
  int item_count     = 0;

  // register values the frames are built against
  logic [7:0]  cur_start = 8'hA5;
  logic [7:0]  cur_hinit = 8'hFF;
  logic [15:0] cur_finit = 16'hFFFF;

  logic [7:0]  frame_q[$];

  referee_frame_deframer_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .command_id     (command_id),
    .payload_length (payload_length),
    .sequence_res   (sequence_res),
    .last           (last)
  );

  referee_frame_deframer_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .command_id     (command_id),
    .payload_length (payload_length),
    .sequence_res   (sequence_res),
    .last           (last),
    .mismatch_count (mismatch_count),
    .backlog        (backlog),
    .payload_count  (payload_count),
    .good_count     (good_count),
    .bad_count      (bad_count)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (rx_hold_left != 0) begin
      out_ready    <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_seen != hold_req_count) begin
      hold_seen    <= hold_req_count;
      rx_hold_left <= HOLD_CYCLES - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: only cycles without any transfer count towards the limit
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results still due",
               STALL_LIMIT, backlog);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // offer one byte from the falling edge, with random idle cycles before it,
  // and return at the rising edge that takes it
  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_span(input int lo, input int hi);
    for (int i = lo; i < hi; i++) push_byte(frame_q[i]);
    item_count += hi - lo;
  endtask

  // header and body with random content; crc bytes are filled in by seal_frame
  task automatic draft_frame(input logic [15:0] plen);
    frame_q = {};
    frame_q.push_back(cur_start);
    frame_q.push_back(plen[7:0]);
    frame_q.push_back(plen[15:8]);
    frame_q.push_back(8'($urandom_range(255)));
    frame_q.push_back(8'h00);
    frame_q.push_back(8'($urandom_range(255)));
    frame_q.push_back(8'($urandom_range(255)));
    repeat (plen) frame_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic seal_frame();
    logic [7:0]  h;
    logic [15:0] f;
    h = cur_hinit;
    for (int i = 0; i < 4; i++) h = rfd_pkg::crc8_add(h, frame_q[i]);
    frame_q[4] = h;
    f = cur_finit;
    foreach (frame_q[i]) f = rfd_pkg::crc16_add(f, frame_q[i]);
    frame_q.push_back(f[7:0]);
    frame_q.push_back(f[15:8]);
  endtask

  // stop offering and wait until every due result has been taken
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    // margin after the last result before going on
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_config(input logic [7:0] s, input logic [7:0] h,
                              input logic [15:0] f);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= rfd_pkg::REG_START_BYTE;
    cfg_data  <= {8'($urandom_range(255)), s};
    @(negedge clk);
    cfg_index <= rfd_pkg::REG_HEADER_CRC_INIT;
    cfg_data  <= {8'($urandom_range(255)), h};
    @(negedge clk);
    cfg_index <= rfd_pkg::REG_FRAME_CRC_INIT;
    cfg_data  <= f;
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_start = s;
    cur_hinit = h;
    cur_finit = f;
  endtask

  task automatic send_random_frame();
    int          pick;
    int          plen;
    int          spot;
    logic [15:0] big;
    pick = $urandom_range(99);
    // mostly short payloads, now and then long ones up to the limit
    plen = ($urandom_range(99) < 4) ? $urandom_range(rfd_pkg::LEN_LIMIT - 1, 13)
                                    : $urandom_range(12, 0);
    if ($urandom_range(99) == 0) plen = rfd_pkg::LEN_LIMIT - 1;
    if (pick < 68) begin
      draft_frame(16'(plen));
      seal_frame();
      send_span(0, frame_q.size());
    end else if (pick < 80) begin
      // one flipped bit after the header: crc16 verdict must be bad
      draft_frame(16'(plen));
      seal_frame();
      spot = $urandom_range(frame_q.size() - 1, 5);
      frame_q[spot] ^= 8'(1 << $urandom_range(7));
      send_span(0, frame_q.size());
    end else if (pick < 88) begin
      // broken header crc8, the rest of the frame turns into line noise
      draft_frame(16'(plen));
      seal_frame();
      frame_q[4] ^= 8'($urandom_range(255, 1));
      send_span(0, frame_q.size());
    end else if (pick < 94) begin
      // oversize length, either from the limit up to 255 in the low byte or 256 and above
      big = $urandom_range(1) ? {8'h00, 8'($urandom_range(255, rfd_pkg::LEN_LIMIT))}
                              : 16'($urandom_range(65535, 256));
      frame_q = '{cur_start, big[7:0], big[15:8]};
      send_span(0, 3);
    end else begin
      repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int base;
    int goal;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part, reset register values, no idling ----
    // stray bytes while hunting for the start byte
    push_byte(8'h00);
    push_byte(8'hFF);
    // oversize length whose high byte equals the start byte: not a new frame
    frame_q = '{cur_start, 8'h00, cur_start};
    send_span(0, 3);
    // header crc8 failure, wrong crc byte equal to the start byte
    draft_frame(16'd0);
    frame_q[3] = 8'hFF;
    seal_frame();
    frame_q[4] = (frame_q[4] == cur_start) ? (frame_q[4] ^ 8'h01) : cur_start;
    send_span(0, 5);
    // two payload bytes at the extremes, bad crc16
    draft_frame(16'd2);
    frame_q[3] = 8'h00;
    frame_q[5] = 8'hFF;
    frame_q[6] = 8'hFF;
    frame_q[7] = 8'h00;
    frame_q[8] = 8'hFF;
    seal_frame();
    frame_q[frame_q.size() - 1] ^= 8'h80;
    send_span(0, frame_q.size());
    // zero-length frame, registers rewritten in the middle: still good,
    // the crc init values only load at the next start byte
    draft_frame(16'd0);
    frame_q[3] = 8'hFF;
    frame_q[5] = 8'h00;
    frame_q[6] = 8'h00;
    seal_frame();
    send_span(0, 6);
    quiesce();
    apply_config(8'h3C, 8'h00, 16'h0000);
    send_span(6, frame_q.size());

    // ---- random part: six register settings, three pacing modes ----
    base = item_count;
    for (int seg = 0; seg < 6; seg++) begin
      // sender pauses until every result is in before touching registers
      quiesce();
      case (seg)
        0:       apply_config(8'hA5, 8'hFF, 16'hFFFF);
        1:       apply_config(8'h00, 8'h00, 16'h0000);
        3:       apply_config(8'hFF, 8'h80, 16'h0001);
        5:       apply_config(8'h7E, 8'($urandom_range(255)), 16'($urandom_range(65535)));
        default: apply_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                              16'($urandom_range(65535)));
      endcase
      case (seg / 2)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 83;
        end
        1: begin
          send_idle_pct = 83;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // long receiver hold-off while a long frame keeps coming: input backs up
      hold_req_count = hold_req_count + 1;
      draft_frame(16'd60);
      seal_frame();
      send_span(0, frame_q.size());
      goal = base + RANDOM_ITEMS * (seg + 1) / 6;
      while (item_count < goal) send_random_frame();
    end

    quiesce();
    $display("run covered %0d frame bytes: %0d payload results, %0d good and %0d bad verdicts",
             item_count, payload_count, good_count, bad_count);
    $display("across six register settings, three pacing modes and long output hold-offs");
    if (mismatch_count == 0 && backlog == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rfd_pkg.sv
rtl/rfd_step.sv
rtl/referee_frame_deframer_core.sv
bench/referee_frame_deframer_checker.sv
bench/tb_referee_frame_deframer_core.sv
